FILE: src/bqlpf_pkg.sv
`timescale 1ns / 1ps

package bqlpf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_FRAC  = 16;
    localparam int COEF_W     = COEF_FRAC + 2;
    localparam int STATE_W    = 40;
    localparam int STATE_FRAC = 8;

    localparam int SPLIT      = STATE_W / 2;
    localparam int PART_W     = SPLIT + 1;
    localparam int PROD_W     = COEF_W + PART_W;
    localparam int ACC_W      = COEF_W + STATE_W + 2;
    localparam int Y_SHIFT    = COEF_FRAC + STATE_FRAC;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    localparam logic [CFG_IDX_W-1:0] REG_BYPASS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd5;

    localparam logic [2:0] SEL_B0 = 3'd0;
    localparam logic [2:0] SEL_B1 = 3'd1;
    localparam logic [2:0] SEL_B2 = 3'd2;
    localparam logic [2:0] SEL_A1 = 3'd3;
    localparam logic [2:0] SEL_A2 = 3'd4;

    localparam logic [1:0] DAT_D1 = 2'd0;
    localparam logic [1:0] DAT_D2 = 2'd1;
    localparam logic [1:0] DAT_W  = 2'd2;

    typedef struct packed {
        logic       load_x;
        logic       clr_state;
        logic       mul_en;
        logic [2:0] coef_sel;
        logic [1:0] dat_sel;
        logic       half;
        logic       neg;
        logic       round_w;
        logic       round_y;
        logic       out_pass;
    } t_cmd;

    typedef struct packed {
        logic bypass;
        logic out_free;
    } t_stat;

endpackage

FILE: src/bqlpf_ctrl.sv
`timescale 1ns / 1ps

module bqlpf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_kind,
    output logic            o_in_stall,
    input  bqlpf_pkg::t_stat i_stat,
    output bqlpf_pkg::t_cmd  o_cmd
);
    import bqlpf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WMUL = 3'd1;
    localparam logic [2:0] S_WDRN = 3'd2;
    localparam logic [2:0] S_WRND = 3'd3;
    localparam logic [2:0] S_YMUL = 3'd4;
    localparam logic [2:0] S_YDRN = 3'd5;
    localparam logic [2:0] S_YRND = 3'd6;
    localparam logic [2:0] S_PASS = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    if (i_kind) begin
                        o_cmd.clr_state = 1'b1;
                    end else begin
                        o_cmd.load_x = 1'b1;
                        n_state = i_stat.bypass ? S_PASS : S_WMUL;
                    end
                end
            end
            S_WMUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.neg      = 1'b1;
                o_cmd.half     = r_step[0];
                o_cmd.coef_sel = r_step[1] ? SEL_A2 : SEL_A1;
                o_cmd.dat_sel  = r_step[1] ? DAT_D2 : DAT_D1;
                n_step = r_step + 3'd1;
                if (r_step == 3'd3) begin
                    n_state = S_WDRN;
                end
            end
            S_WDRN: begin
                n_state = S_WRND;
            end
            S_WRND: begin
                o_cmd.round_w = 1'b1;
                n_step  = '0;
                n_state = S_YMUL;
            end
            S_YMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.half   = r_step[0];
                case (r_step[2:1])
                    2'd0: begin
                        o_cmd.coef_sel = SEL_B0;
                        o_cmd.dat_sel  = DAT_W;
                    end
                    2'd1: begin
                        o_cmd.coef_sel = SEL_B1;
                        o_cmd.dat_sel  = DAT_D1;
                    end
                    default: begin
                        o_cmd.coef_sel = SEL_B2;
                        o_cmd.dat_sel  = DAT_D2;
                    end
                endcase
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_state = S_YDRN;
                end
            end
            S_YDRN: begin
                n_state = S_YRND;
            end
            S_YRND: begin
                if (i_stat.out_free) begin
                    o_cmd.round_y = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PASS: begin
                if (i_stat.out_free) begin
                    o_cmd.out_pass = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/bqlpf_dp.sv
`timescale 1ns / 1ps

module bqlpf_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [bqlpf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [bqlpf_pkg::SAMPLE_W-1:0] o_filtered,
    input  logic                                i_cfg_we,
    input  logic [bqlpf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bqlpf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  bqlpf_pkg::t_cmd                     i_cmd,
    output bqlpf_pkg::t_stat                    o_stat
);
    import bqlpf_pkg::*;

    localparam int WR_W = ACC_W - COEF_FRAC;
    localparam int YR_W = ACC_W - Y_SHIFT;
    localparam int X_SH = STATE_FRAC + COEF_FRAC;
    localparam logic [ACC_W-1:0] W_HALF = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic [ACC_W-1:0] Y_HALF = ACC_W'(1) << (Y_SHIFT - 1);
    localparam logic [STATE_W-1:0]  STATE_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    logic                      r_bypass;
    logic signed [COEF_W-1:0]  r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [STATE_W-1:0] r_d1, r_d2, r_w;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_prod_vld, r_prod_hi, r_prod_neg;
    logic                      r_out_valid;
    logic signed [SAMPLE_W-1:0] r_filtered;

    logic signed [COEF_W-1:0]  coef;
    logic signed [STATE_W-1:0] dat;
    logic signed [PART_W-1:0]  part;
    logic signed [PROD_W-1:0]  prod;
    logic [ACC_W-1:0]          prod_ext, term;
    logic [ACC_W-1:0]          w_sum, y_sum;
    logic [WR_W-1:0]           w_rnd;
    logic [YR_W-1:0]           y_rnd;
    logic [STATE_W-1:0]        w_sat;
    logic [SAMPLE_W-1:0]       y_sat;
    logic                      out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b1;
            r_b0 <= '0;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BYPASS:  r_bypass <= i_cfg_data[0];
                REG_COEF_B0: r_b0 <= i_cfg_data;
                REG_COEF_B1: r_b1 <= i_cfg_data;
                REG_COEF_B2: r_b2 <= i_cfg_data;
                REG_COEF_A1: r_a1 <= i_cfg_data;
                REG_COEF_A2: r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.coef_sel)
            SEL_B0:  coef = r_b0;
            SEL_B1:  coef = r_b1;
            SEL_B2:  coef = r_b2;
            SEL_A1:  coef = r_a1;
            SEL_A2:  coef = r_a2;
            default: coef = r_b0;
        endcase
        unique case (i_cmd.dat_sel)
            DAT_D1:  dat = r_d1;
            DAT_D2:  dat = r_d2;
            DAT_W:   dat = r_w;
            default: dat = r_d1;
        endcase
    end

    assign part = i_cmd.half
                ? {dat[STATE_W-1], dat[STATE_W-1:SPLIT]}
                : {1'b0, dat[SPLIT-1:0]};
    assign prod = coef * part;

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign term = r_prod_hi ? {prod_ext[ACC_W-1-SPLIT:0], {SPLIT{1'b0}}} : prod_ext;

    assign w_sum = r_acc + W_HALF;
    assign w_rnd = w_sum[ACC_W-1:COEF_FRAC];
    assign w_sat = (&w_rnd[WR_W-1:STATE_W-1] || ~|w_rnd[WR_W-1:STATE_W-1])
                 ? w_rnd[STATE_W-1:0]
                 : (w_rnd[WR_W-1] ? ~STATE_MAX : STATE_MAX);

    assign y_sum = r_acc + Y_HALF;
    assign y_rnd = y_sum[ACC_W-1:Y_SHIFT];
    assign y_sat = (&y_rnd[YR_W-1:SAMPLE_W-1] || ~|y_rnd[YR_W-1:SAMPLE_W-1])
                 ? y_rnd[SAMPLE_W-1:0]
                 : (y_rnd[YR_W-1] ? ~SAMPLE_MAX : SAMPLE_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod     <= prod;
            r_prod_hi  <= i_cmd.half;
            r_prod_neg <= i_cmd.neg;
        end
        if (i_cmd.load_x) begin
            r_x   <= i_sample;
            r_acc <= {{(ACC_W-SAMPLE_W-X_SH){i_sample[SAMPLE_W-1]}}, i_sample,
                      {X_SH{1'b0}}};
        end else if (i_cmd.round_w) begin
            r_w   <= w_sat;
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_prod_neg ? r_acc - term : r_acc + term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_cmd.clr_state) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_cmd.round_y) begin
            r_d1 <= r_w;
            r_d2 <= r_d1;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.round_y || i_cmd.out_pass) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.round_y) begin
            r_filtered <= y_sat;
        end else if (i_cmd.out_pass) begin
            r_filtered <= r_x;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_filtered      = r_filtered;
    assign o_stat.bypass   = r_bypass;
    assign o_stat.out_free = out_free;

endmodule

FILE: src/biquad_lowpass_filter.sv
`timescale 1ns / 1ps
// Second-order low-pass IIR (direct form II), fixed point.
// Input channel: i_in_valid / o_in_stall carry one word of i_kind and i_sample.
//   i_kind = 1 zeroes both delay elements and gives no output word.
// Output channel: o_out_valid / i_out_stall carry o_filtered from an output
//   register; a new input word is taken while a result still waits there.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 bypass, 1..3 b0..b2, 4 a1, 5 a2); write only while the block is idle.
// Timing: an accepted sample runs the feedback products, a drain step and the
//   rounding of w, then the feedforward products, a drain step and the rounding
//   of y; only then is the next word taken. A bypassed sample goes to the output
//   register. One 18 x 21 multiplier forms the ten partial products of each sample.
// Stall: a finished result holds in the output register; a later result
//   waits in the last step until the register is free.
// Reset (synchronous, active low): bypass on, coefficients and delay line
//   zero, no output word pending.
module biquad_lowpass_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic signed [bqlpf_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [bqlpf_pkg::SAMPLE_W-1:0] o_filtered,
    input  logic                                i_cfg_we,
    input  logic [bqlpf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bqlpf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bqlpf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bqlpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bqlpf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_sample),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_filtered  (o_filtered),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

FILE: verif/tb_biquad_lowpass_filter.sv
`timescale 1ns / 1ps

module tb_biquad_lowpass_filter;

    import bqlpf_pkg::*;

    localparam logic KIND_SAMPLE     = 1'b0;
    localparam logic KIND_CLEAR      = 1'b1;
    localparam int   WIDE_W          = 96;
    localparam int   QUIET_LIMIT     = 4000;
    localparam int   SETTLE_CYCLES   = 24;
    localparam int   HOLD_CYCLES     = 300;
    localparam int   RANDOM_PHASES   = 12;
    localparam int   WORDS_PER_PHASE = 140;
    localparam int   FLOOD_WORDS     = 20;

    typedef logic signed [WIDE_W-1:0]   wide_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [STATE_W-1:0]  state_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {COEF_STABLE, COEF_ANY, COEF_EXTREME} coef_style_t;

    localparam coef_t COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam coef_t COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam coef_t COEF_UNITY = coef_t'(1) <<< COEF_FRAC;
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_kind      = KIND_SAMPLE;
    sample_t               i_sample    = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_BYPASS;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    sample_t               o_filtered;

    logic    bypass_on = 1'b1;
    coef_t   coef_b0 = '0, coef_b1 = '0, coef_b2 = '0, coef_a1 = '0, coef_a2 = '0;
    state_t  delay_one = '0, delay_two = '0;
    sample_t pending_filtered [$];

    int   mismatches   = 0;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    int   quiet_cycles = 0;
    int   hold_left    = 0;
    logic hold_req     = 1'b0;

    biquad_lowpass_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_filtered  (o_filtered),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic wide_t clamp(wide_t v, int bits);
        wide_t top;
        top = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
        if (v > top) return top;
        if (v < -top - wide_t'(1)) return -top - wide_t'(1);
        return v;
    endfunction

    task automatic compute_filtered(logic kind, sample_t x);
        wide_t   acc;
        state_t  w;
        sample_t y;
        if (kind == KIND_CLEAR) begin
            delay_one = '0;
            delay_two = '0;
            return;
        end
        if (bypass_on) begin
            pending_filtered.push_back(x);
            return;
        end
        acc = (wide_t'(x) <<< (STATE_FRAC + COEF_FRAC))
            - wide_t'(coef_a1) * wide_t'(delay_one)
            - wide_t'(coef_a2) * wide_t'(delay_two);
        w = state_t'(clamp((acc + (wide_t'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC, STATE_W));
        acc = wide_t'(coef_b0) * wide_t'(w)
            + wide_t'(coef_b1) * wide_t'(delay_one)
            + wide_t'(coef_b2) * wide_t'(delay_two);
        y = sample_t'(clamp((acc + (wide_t'(1) <<< (Y_SHIFT - 1))) >>> Y_SHIFT, SAMPLE_W));
        delay_two = delay_one;
        delay_one = w;
        pending_filtered.push_back(y);
    endtask

    always @(posedge i_clk) begin : track_words
        sample_t want;
        if (!i_rst_n) begin
            bypass_on = 1'b1;
            coef_b0   = '0;
            coef_b1   = '0;
            coef_b2   = '0;
            coef_a1   = '0;
            coef_a2   = '0;
            delay_one = '0;
            delay_two = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BYPASS:  bypass_on = i_cfg_data[0];
                    REG_COEF_B0: coef_b0   = coef_t'(i_cfg_data);
                    REG_COEF_B1: coef_b1   = coef_t'(i_cfg_data);
                    REG_COEF_B2: coef_b2   = coef_t'(i_cfg_data);
                    REG_COEF_A1: coef_a1   = coef_t'(i_cfg_data);
                    REG_COEF_A2: coef_a2   = coef_t'(i_cfg_data);
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_filtered.size() == 0) begin
                    mismatches++;
                    $display("%0t: filtered word with none expected, actual %0d",
                             $time, o_filtered);
                end else begin
                    want = pending_filtered.pop_front();
                    if (o_filtered !== want) begin
                        mismatches++;
                        $display("%0t: filtered expected %0d actual %0d",
                                 $time, want, o_filtered);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) compute_filtered(i_kind, i_sample);
        end
    end

    // hold off for a long stretch on request, else stall at random
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we
                || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(idle_mode_t mode);
        idle_pct  = (mode == IDLE_SENDER) ? 49 : (mode == IDLE_BOTH) ? 37 : 0;
        stall_pct = (mode == IDLE_RECEIVER) ? 49 : (mode == IDLE_BOTH) ? 37 : 0;
    endtask

    task automatic send_word(logic kind, sample_t x);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_sample   <= x;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_filtered.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(logic byp, coef_t b0, coef_t b1, coef_t b2,
                               coef_t a1, coef_t a2);
        logic [CFG_DATA_W-1:0] vals [REG_COEF_A2+1];
        vals[REG_BYPASS]  = CFG_DATA_W'(byp);
        vals[REG_COEF_B0] = b0;
        vals[REG_COEF_B1] = b1;
        vals[REG_COEF_B2] = b2;
        vals[REG_COEF_A1] = a1;
        vals[REG_COEF_A2] = a2;
        for (int r = REG_BYPASS; r <= REG_COEF_A2; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(r);
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic coef_t random_coef(coef_style_t style, bit feedback_two, int a2_val);
        int lim;
        case (style)
            COEF_ANY: return coef_t'($urandom);
            COEF_EXTREME: begin
                case ($urandom_range(0, 2))
                    0: return COEF_MIN;
                    1: return COEF_MAX;
                    default: return '0;
                endcase
            end
            default: begin
                if (feedback_two) return coef_t'(a2_val);
                lim = 65536 + a2_val - 1000;
                return coef_t'(int'($urandom_range(0, 2 * lim)) - lim);
            end
        endcase
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 19))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return '1;
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic test_bypass_after_reset();
        set_idling(IDLE_NONE);
        send_word(KIND_SAMPLE, SAMPLE_MIN);
        send_word(KIND_SAMPLE, SAMPLE_MAX);
        send_word(KIND_SAMPLE, '0);
        send_word(KIND_SAMPLE, '1);
        send_word(KIND_CLEAR, SAMPLE_MAX);
        send_word(KIND_SAMPLE, sample_t'(1));
        send_word(KIND_SAMPLE, sample_t'(16'h5a5a));
        wait_drained();
    endtask

    task automatic test_unity_gain();
        load_config(1'b0, COEF_UNITY, '0, '0, '0, '0);
        send_word(KIND_SAMPLE, SAMPLE_MIN);
        send_word(KIND_SAMPLE, SAMPLE_MAX);
        send_word(KIND_SAMPLE, sample_t'(-12345));
        wait_drained();
    endtask

    // drive the delay line and the output into saturation
    task automatic test_saturation();
        load_config(1'b0, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        repeat (12) send_word(KIND_SAMPLE, SAMPLE_MAX);
        repeat (2) send_word(KIND_SAMPLE, SAMPLE_MIN);
        wait_drained();
    endtask

    task automatic test_clear_in_bypass();
        load_config(1'b1, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        send_word(KIND_CLEAR, '0);
        wait_drained();
        load_config(1'b0, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        send_word(KIND_SAMPLE, SAMPLE_MIN);
        wait_drained();
    endtask

    task automatic test_random_phases();
        coef_style_t style;
        int          a2_val;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            style  = coef_style_t'(p % 3);
            a2_val = int'($urandom_range(0, 120000)) - 60000;
            set_idling(idle_mode_t'(p % 4));
            if (style == COEF_STABLE)
                load_config(p % 6 == 5,
                            coef_t'(int'($urandom_range(0, 60000)) - 30000),
                            coef_t'(int'($urandom_range(0, 60000)) - 30000),
                            coef_t'(int'($urandom_range(0, 60000)) - 30000),
                            random_coef(style, 1'b0, a2_val),
                            random_coef(style, 1'b1, a2_val));
            else
                load_config(p % 6 == 5,
                            random_coef(style, 1'b0, a2_val),
                            random_coef(style, 1'b0, a2_val),
                            random_coef(style, 1'b0, a2_val),
                            random_coef(style, 1'b0, a2_val),
                            random_coef(style, 1'b1, a2_val));
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_word(($urandom_range(0, 24) == 0) ? KIND_CLEAR : KIND_SAMPLE,
                          random_sample());
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        set_idling(IDLE_NONE);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        repeat (FLOOD_WORDS) send_word(KIND_SAMPLE, random_sample());
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bypass_after_reset();
        test_unity_gain();
        test_saturation();
        test_clear_in_bypass();
        test_random_phases();
        test_backpressure();
        wait_drained();
        if (mismatches == 0 && pending_filtered.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: biquad_lowpass_filter.f
src/bqlpf_pkg.sv
src/bqlpf_ctrl.sv
src/bqlpf_dp.sv
src/biquad_lowpass_filter.sv
verif/tb_biquad_lowpass_filter.sv
